@@ rtl/rau_pkg.sv @@
`default_nettype none
package rau_pkg;
  localparam int W = 64;
  typedef logic signed [W-1:0] word_t;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  // Datapath operation codes issued by the controller.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_COMB = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_GSTEP = 3'd5;
  localparam logic [2:0] OP_FIN  = 3'd6;

  // Multiplier operand selects for the products.
  localparam logic [1:0] MSEL_C1 = 2'd0;
  localparam logic [1:0] MSEL_C2 = 2'd1;
  localparam logic [1:0] MSEL_Q  = 2'd2;
  localparam logic [1:0] MSEL_P  = 2'd3;

  // Divider operand selects.
  localparam logic [1:0] DSEL_GCD = 2'd0;
  localparam logic [1:0] DSEL_P   = 2'd1;
  localparam logic [1:0] DSEL_Q   = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] msel;
    logic [1:0] dsel;
    logic       div_start;
  } rau_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic x_zero;
    logic ovf;
  } rau_sts_t;
endpackage
`default_nettype wire

@@ rtl/rau_mul.sv @@
`default_nettype none
module rau_mul
  import rau_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire word_t        a,
  input  wire word_t        b,
  output logic              done,
  output word_t             prod,
  output logic              ovf
);
  // Radix-2 magnitude shift-add multiplier producing the exact 128-bit
  // product: one partial product per cycle.
  logic [W-1:0]   ma_r, ma_nxt;
  logic [2*W-1:0] acc_r, acc_nxt, mb_r, mb_nxt;
  logic [6:0]     cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [2*W-1:0] full;

  always_comb begin
    ma_nxt = ma_r; mb_nxt = mb_r; acc_nxt = acc_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    if (start) begin
      ma_nxt  = a[W-1] ? (~a + 1'b1) : a;
      mb_nxt  = {{W{1'b0}}, (b[W-1] ? (~b + 1'b1) : b)};
      neg_nxt = a[W-1] ^ b[W-1];
      acc_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ma_r[0]) acc_nxt = acc_r + mb_r;
      ma_nxt = ma_r >> 1;
      mb_nxt = mb_r << 1;
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    ma_r <= ma_nxt; mb_r <= mb_nxt; acc_r <= acc_nxt; neg_r <= neg_nxt;
  end

  assign full = neg_r ? (~acc_r + 1'b1) : acc_r;
  assign prod = full[W-1:0];
  assign ovf  = (full[2*W-1:W-1] != {(W+1){full[W-1]}});
  assign done = done_r;
endmodule
`default_nettype wire

@@ rtl/rau_div.sv @@
`default_nettype none
module rau_div
  import rau_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire word_t dvd,
  input  wire word_t dvs,
  output logic       done,
  output word_t      quo,
  output word_t      rem
);
  // Restoring radix-2 divider on magnitudes, C truncation semantics.
  // Wraps for most-negative / -1; a remainder by -1 gives 0 naturally.
  logic [W-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [W:0]   r_r, r_nxt, trial;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt, done_r, done_nxt;
  logic         qneg_r, qneg_nxt, rneg_r, rneg_nxt;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; r_nxt = r_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    qneg_nxt = qneg_r; rneg_nxt = rneg_r;
    trial = '0;
    if (start) begin
      q_nxt = dvd[W-1] ? (~dvd + 1'b1) : dvd;
      d_nxt = dvs[W-1] ? (~dvs + 1'b1) : dvs;
      r_nxt = '0;
      qneg_nxt = dvd[W-1] ^ dvs[W-1];
      rneg_nxt = dvd[W-1];
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {r_r[W-1:0], q_r[W-1]} - {1'b0, d_r};
      if (!trial[W]) begin
        r_nxt = trial;
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[W-1:0], q_r[W-1]};
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; r_r <= r_nxt; qneg_r <= qneg_nxt; rneg_r <= rneg_nxt;
  end

  assign quo  = qneg_r ? (~q_r + 1'b1) : q_r;
  assign rem  = rneg_r ? (~r_r[W-1:0] + 1'b1) : r_r[W-1:0];
  assign done = done_r;
endmodule
`default_nettype wire

@@ rtl/rau_datapath.sv @@
`default_nettype none
module rau_datapath
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rau_cmd_t cmd,
  output rau_sts_t      sts,
  input  wire logic     safe_mode,
  input  wire logic [1:0] in_func,
  input  wire word_t    in_a_num,
  input  wire word_t    in_a_den,
  input  wire word_t    in_b_num,
  input  wire word_t    in_b_den,
  output word_t         res_num,
  output word_t         res_den,
  output logic          res_ovf,
  output logic          res_less,
  output logic          res_equal,
  output logic          res_greater
);
  logic [1:0] func_r;
  word_t an_r, ad_r, bn_r, bd_r;
  word_t c1_r, c2_r, q_r, p_r, x_r, y_r;
  logic  ovf_r, ovf_nxt;
  word_t ma, mb, dd, ds, mprod, quo, rem, sum, diff, pc, ax, ay;
  logic  movf, sovf, dovf, mul_chk, mul_done, div_done;

  rau_mul u_mul (.clk, .rst_n, .start(cmd.op == OP_MUL), .a(ma), .b(mb),
                 .done(mul_done), .prod(mprod), .ovf(movf));
  rau_div u_div (.clk, .rst_n, .start(cmd.div_start), .dvd(dd), .dvs(ds),
                 .done(div_done), .quo(quo), .rem(rem));

  // Multiplier operand selection per product and operation.
  always_comb begin
    ma = an_r; mb = bd_r;
    case (cmd.msel)
      MSEL_C1: begin ma = an_r; mb = bd_r; end
      MSEL_C2: begin ma = bn_r; mb = ad_r; end
      MSEL_Q:  begin ma = ad_r; mb = (func_r == FUNC_DIV) ? bn_r : bd_r; end
      MSEL_P:  begin ma = an_r; mb = bn_r; end
    endcase
  end

  always_comb begin
    dd = y_r; ds = x_r;
    case (cmd.dsel)
      DSEL_P:  begin dd = p_r; ds = y_r; end
      DSEL_Q:  begin dd = q_r; ds = y_r; end
      default: begin dd = y_r; ds = x_r; end
    endcase
  end

  // Cross products that only feed the compare flags are not checked for overflow.
  always_comb begin
    mul_chk = 1'b1;
    if (cmd.msel == MSEL_C1 && func_r == FUNC_MUL) mul_chk = 1'b0;
    if (cmd.msel == MSEL_C2 && (func_r == FUNC_MUL || func_r == FUNC_DIV)) mul_chk = 1'b0;
  end

  assign sum  = c1_r + c2_r;
  assign diff = c1_r - c2_r;
  assign sovf = (c1_r[W-1] == c2_r[W-1]) && (sum[W-1] != c1_r[W-1]);
  assign dovf = (c1_r[W-1] != c2_r[W-1]) && (diff[W-1] != c1_r[W-1]);

  // Raw numerator as it stands once the sum or difference is formed.
  always_comb begin
    pc = p_r;
    if (func_r == FUNC_ADD) pc = sum;
    if (func_r == FUNC_SUB) pc = diff;
  end

  assign ax   = pc[W-1] ? (~pc + 1'b1) : pc;
  assign ay   = q_r[W-1] ? (~q_r + 1'b1) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else begin
      ovf_r <= ovf_nxt;
    end
    case (cmd.op)
      OP_LOAD: begin
        func_r <= in_func;
        an_r <= in_a_num; ad_r <= in_a_den; bn_r <= in_b_num; bd_r <= in_b_den;
      end
      OP_COMB: begin
        p_r <= pc;
        x_r <= ax; y_r <= ay;
      end
      OP_GSTEP: begin
        y_r <= x_r; x_r <= (x_r == {W{1'b1}}) ? '0 : rem;
      end
      default: begin end
    endcase
    if (mul_done) begin
      case (cmd.msel)
        MSEL_C1: begin
          c1_r <= mprod;
          if (func_r == FUNC_DIV) p_r <= mprod;
        end
        MSEL_C2: c2_r <= mprod;
        MSEL_Q:  q_r <= mprod;
        MSEL_P:  p_r <= mprod;
      endcase
    end
    if (cmd.op == OP_DIV && div_done) begin
      if (cmd.dsel == DSEL_P) p_r <= quo;
      if (cmd.dsel == DSEL_Q) q_r <= quo;
    end
  end

  always_comb begin
    ovf_nxt = ovf_r;
    if (cmd.op == OP_LOAD) ovf_nxt = 1'b0;
    if (mul_done && safe_mode && movf && mul_chk) ovf_nxt = 1'b1;
    if (cmd.op == OP_COMB && safe_mode && !ovf_r) begin
      if (func_r == FUNC_ADD && sovf) ovf_nxt = 1'b1;
      if (func_r == FUNC_SUB && dovf) ovf_nxt = 1'b1;
    end
    if (cmd.op == OP_FIN && (y_r == '0 || y_r == {W{1'b1}})) ovf_nxt = 1'b1;
  end

  assign sts = '{mul_done: mul_done, div_done: div_done, x_zero: (x_r == '0), ovf: ovf_r};

  always_comb begin
    res_num = p_r; res_den = q_r;
    if (p_r[W-1] && q_r[W-1]) begin
      res_num = ~p_r + 1'b1; res_den = ~q_r + 1'b1;
    end
    if (ovf_r) begin
      res_num = '0; res_den = '0;
    end
  end
  assign res_ovf     = ovf_r;
  assign res_less    = c1_r < c2_r;
  assign res_equal   = c1_r == c2_r;
  assign res_greater = c1_r > c2_r;
endmodule
`default_nettype wire

@@ rtl/rau_ctrl.sv @@
`default_nettype none
module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire logic [1:0] in_func,
  output logic          capture,
  output rau_cmd_t      cmd,
  input  wire rau_sts_t sts
);
  localparam logic [3:0] S_IDLE = 4'd0, S_M1 = 4'd1, S_M2 = 4'd2, S_M3 = 4'd3,
                         S_COMB = 4'd4, S_GS = 4'd5, S_GW = 4'd6, S_FIN = 4'd7,
                         S_DP = 4'd8, S_DPW = 4'd9, S_DQ = 4'd10, S_DQW = 4'd11,
                         S_OUT = 4'd12, S_M4 = 4'd13;
  logic [3:0] st_r, st_nxt;
  logic [1:0] func_r;
  logic       started_r, started_nxt;

  // The result registers are held in the datapath; a finished item waits in
  // S_OUT, then is copied into the top-level output register.
  always_comb begin
    st_nxt = st_r; started_nxt = 1'b0;
    cmd = '{op: OP_NONE, msel: MSEL_C1, dsel: DSEL_GCD, div_start: 1'b0};
    capture = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_valid) begin cmd.op = OP_LOAD; st_nxt = S_M1; started_nxt = 1'b1; end
      S_M1: begin
        cmd.msel = MSEL_C1;
        if (started_r) cmd.op = OP_MUL;
        if (sts.mul_done) begin st_nxt = S_M2; started_nxt = 1'b1; end
      end
      S_M2: begin
        cmd.msel = MSEL_C2;
        if (started_r) cmd.op = OP_MUL;
        if (sts.mul_done) begin st_nxt = S_M3; started_nxt = 1'b1; end
      end
      S_M3: begin
        cmd.msel = MSEL_Q;
        if (started_r) cmd.op = OP_MUL;
        if (sts.mul_done) begin
          if (func_r == FUNC_MUL) begin
            st_nxt = S_M4; started_nxt = 1'b1;
          end else begin
            st_nxt = S_COMB;
          end
        end
      end
      S_M4: begin
        cmd.msel = MSEL_P;
        if (started_r) cmd.op = OP_MUL;
        if (sts.mul_done) st_nxt = S_COMB;
      end
      S_COMB: begin cmd.op = OP_COMB; st_nxt = S_GS; end
      S_GS: begin
        if (sts.ovf) st_nxt = S_OUT;
        else if (sts.x_zero) st_nxt = S_FIN;
        else begin cmd.div_start = 1'b1; st_nxt = S_GW; end
      end
      S_GW: if (sts.div_done) begin cmd.op = OP_GSTEP; st_nxt = S_GS; end
      S_FIN: begin cmd.op = OP_FIN; st_nxt = S_DP; end
      S_DP: begin
        cmd.dsel = DSEL_P;
        if (sts.ovf) st_nxt = S_OUT;
        else begin cmd.div_start = 1'b1; st_nxt = S_DPW; end
      end
      S_DPW: begin
        cmd.dsel = DSEL_P; cmd.op = OP_DIV;
        if (sts.div_done) st_nxt = S_DQ;
      end
      S_DQ: begin cmd.dsel = DSEL_Q; cmd.div_start = 1'b1; st_nxt = S_DQW; end
      S_DQW: begin
        cmd.dsel = DSEL_Q; cmd.op = OP_DIV;
        if (sts.div_done) st_nxt = S_OUT;
      end
      S_OUT: if (!out_valid || !out_stall) begin capture = 1'b1; st_nxt = S_IDLE; end
      default: st_nxt = S_IDLE;
    endcase
  end

  logic ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; started_r <= 1'b0; ov_r <= 1'b0; func_r <= FUNC_ADD;
    end else begin
      st_r <= st_nxt; started_r <= started_nxt;
      if (capture) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (st_r == S_IDLE && in_valid) func_r <= in_func;
    end
  end
  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = ov_r;

`ifndef ASSERT_OFF
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_cap_idle: assert property (@(posedge clk) disable iff (!rst_n)
    capture |=> (st_r == S_IDLE)) else $error("capture without return");
  a_cap_free: assert property (@(posedge clk) disable iff (!rst_n)
    capture |-> (!out_valid || !out_stall)) else $error("overwrote result");
`endif
endmodule
`default_nettype wire

@@ rtl/rational_arith_unit.sv @@
`default_nettype none
// Rational arithmetic unit: adds, subtracts, multiplies or divides two
// signed 64-bit rationals and returns the result reduced by the Euclid gcd,
// with less/equal/greater flags from the wrapped cross products. One item is
// worked at a time. An item takes three shift-add products (four for a
// multiply), then Euclid remainder steps on the one shared radix-2 divider,
// then two more divisions for the reduction. The finished item sits in the
// output register; the next item is taken once that register has been
// loaded. safe_mode is written through the cfg port, which is always ready
// and must only be written while the block is idle.
module rational_arith_unit
  import rau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_safe_mode,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire word_t       in_a_num,
  input  wire word_t       in_a_den,
  input  wire word_t       in_b_num,
  input  wire word_t       in_b_den,
  output logic             out_valid,
  input  wire logic        out_stall,
  output word_t            out_res_num,
  output word_t            out_res_den,
  output logic             out_overflow,
  output logic             out_a_less,
  output logic             out_a_equal,
  output logic             out_a_greater
);
  logic     safe_r, capture;
  rau_cmd_t cmd;
  rau_sts_t sts;
  word_t    rn, rd;
  logic     ro, rl, re, rg;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_r <= 1'b0;
    end else if (cfg_valid) begin
      safe_r <= cfg_safe_mode;
    end
  end

  rau_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
                   .in_func, .capture, .cmd, .sts);

  rau_datapath u_dp (.clk, .rst_n, .cmd, .sts, .safe_mode(safe_r), .in_func,
                     .in_a_num, .in_a_den, .in_b_num, .in_b_den,
                     .res_num(rn), .res_den(rd), .res_ovf(ro), .res_less(rl),
                     .res_equal(re), .res_greater(rg));

  // Output register, loaded once per finished item.
  always_ff @(posedge clk) begin
    if (capture) begin
      out_res_num <= rn; out_res_den <= rd; out_overflow <= ro;
      out_a_less <= rl; out_a_equal <= re; out_a_greater <= rg;
    end
  end
endmodule
`default_nettype wire

@@ verif/rational_arith_unit_tb.sv @@
`default_nettype none
module rational_arith_unit_tb;
  import rau_pkg::*;

  localparam word_t WMAX = {1'b0, {63{1'b1}}};
  localparam word_t WMIN = {1'b1, {63{1'b0}}};
  localparam word_t ONE = 64'sd1;
  localparam word_t NEG1 = -64'sd1;
  localparam int STALL_LIMIT = 40000;
  localparam int HOLD_CYCLES = 500;

  // Idle modes for the two sides of the block.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct {
    logic [1:0] func;
    word_t a_num, a_den, b_num, b_den;
  } operands_t;

  typedef struct {
    word_t num, den;
    bit ovf, lt, eq, gt;
  } quotient_t;

  // One row of the directed table. Rows with typed set carry their answer.
  typedef struct {
    bit safe;
    operands_t op;
    bit typed;
    quotient_t ans;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_safe_mode = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = FUNC_ADD;
  word_t in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t out_res_num, out_res_den;
  logic out_overflow, out_a_less, out_a_equal, out_a_greater;

  quotient_t pending_q[$];
  int errors = 0;
  int idle_mode = IDLE_NONE;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit safe_cur = 1'b0;

  rational_arith_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_safe_mode(cfg_safe_mode),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_overflow(out_overflow), .out_a_less(out_a_less),
    .out_a_equal(out_a_equal), .out_a_greater(out_a_greater)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // True when the exact product of two words fits in a signed word.
  function automatic bit product_fits(word_t a, word_t b);
    logic signed [127:0] pr;
    pr = a * b;
    return pr[127:63] == {65{pr[63]}};
  endfunction

  // Truncating remainder; a divisor of minus one always leaves nothing.
  function automatic word_t trunc_rem(word_t a, word_t b);
    if (b == NEG1) return '0;
    return a % b;
  endfunction

  // Absolute value that wraps, so the most negative word maps to itself.
  function automatic word_t wrap_abs(word_t a);
    word_t z;
    z = a;
    if (a < 0) z = -a;
    return z;
  endfunction

  // Computes the reduced quotient and the compare flags for one item.
  function automatic quotient_t reduce_rational(operands_t o, bit safe);
    quotient_t r;
    word_t c1, c2, p, q, x, y, t;
    logic signed [64:0] sum;
    bit ovf;
    c1 = o.a_num * o.b_den;
    c2 = o.b_num * o.a_den;
    ovf = 1'b0;
    q = o.a_den * o.b_den;
    case (o.func) inside
      FUNC_ADD, FUNC_SUB: begin
        if (o.func == FUNC_ADD) begin
          p = c1 + c2;
          sum = c1 + c2;
        end else begin
          p = c1 - c2;
          sum = c1 - c2;
        end
        if (safe) begin
          ovf = !product_fits(o.a_num, o.b_den) || !product_fits(o.b_num, o.a_den) ||
                !product_fits(o.a_den, o.b_den);
          if (!ovf) ovf = sum[64] != sum[63];
        end
      end
      FUNC_MUL: begin
        p = o.a_num * o.b_num;
        if (safe) ovf = !product_fits(o.a_num, o.b_num) || !product_fits(o.a_den, o.b_den);
      end
      default: begin
        p = c1;
        q = o.a_den * o.b_num;
        if (safe) ovf = !product_fits(o.a_num, o.b_den) || !product_fits(o.a_den, o.b_num);
      end
    endcase
    if (!ovf) begin
      // Euclid loop on the wrapped magnitudes; the gcd may come out negative.
      x = wrap_abs(p);
      y = wrap_abs(q);
      while (x != 0) begin
        t = trunc_rem(y, x);
        y = x;
        x = t;
      end
      if (y == NEG1 || y == 0) begin
        ovf = 1'b1;
      end else begin
        p = p / y;
        q = q / y;
        if (p < 0 && q < 0) begin
          p = -p;
          q = -q;
        end
      end
    end
    r.num = ovf ? '0 : p;
    r.den = ovf ? '0 : q;
    r.ovf = ovf;
    r.lt = c1 < c2;
    r.eq = c1 == c2;
    r.gt = c1 > c2;
    return r;
  endfunction

  task automatic report(string what, word_t got, word_t want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result side: random stall by mode, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (idle_mode == IDLE_RECV) begin
      out_stall <= $urandom_range(99) < 47;
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall <= $urandom_range(99) < 13;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    quotient_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("MISMATCH unexpected result item at %0t", $realtime);
        errors++;
      end else begin
        w = pending_q.pop_front();
        if (out_res_num !== w.num) report("res_num", out_res_num, w.num);
        if (out_res_den !== w.den) report("res_den", out_res_den, w.den);
        if (out_overflow !== w.ovf) report("overflow", out_overflow, w.ovf);
        if (out_a_less !== w.lt) report("a_less", out_a_less, w.lt);
        if (out_a_equal !== w.eq) report("a_equal", out_a_equal, w.eq);
        if (out_a_greater !== w.gt) report("a_greater", out_a_greater, w.gt);
      end
    end
  end

  // A slow item spends its time in the Euclid loop on the divider, so the limit is generous.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("rational_arith_unit verification failed");
        $finish;
      end
    end
  end

  // Withdraws the last item, drains the block, then writes safe_mode while it is idle.
  task automatic set_safe(bit v);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_safe_mode <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    safe_cur = v;
  endtask

  // Offers one item and queues its answer once the block takes it.
  task automatic offer(operands_t o, bit typed, quotient_t ans);
    while ((idle_mode == IDLE_SEND && $urandom_range(99) < 47) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 13)) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= o.func;
    in_a_num <= o.a_num;
    in_a_den <= o.a_den;
    in_b_num <= o.b_num;
    in_b_den <= o.b_den;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(typed ? ans : reduce_rational(o, safe_cur));
  endtask

  // Field values mixing small numbers, shared factors, extremes and full words.
  function automatic word_t pick_word();
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: case ($urandom_range(4))
           0: return WMIN;
           1: return WMAX;
           2: return '0;
           3: return ONE;
           default: return NEG1;
         endcase
      2: return word_t'($urandom_range(200000)) * word_t'($urandom_range(200000));
      3: return -(word_t'($urandom_range(1000)) * 6);
      default: return word_t'($urandom_range(2000)) - 1000;
    endcase
  endfunction

  function automatic quotient_t make_ans(word_t n, word_t d, bit o, bit lt, bit eq, bit gt);
    quotient_t r;
    r.num = n;
    r.den = d;
    r.ovf = o;
    r.lt = lt;
    r.eq = eq;
    r.gt = gt;
    return r;
  endfunction

  initial begin
    row_t rows[$];
    row_t rw;
    operands_t o;
    quotient_t none;
    none = make_ans('0, '0, 0, 0, 0, 0);

    // Directed table. Typed answers: a plain sum, the all-zero gcd error and a
    // safe-mode product overflow. Everything else goes through the predictor.
    rows.push_back('{0, '{FUNC_ADD, 1, 2, 1, 3}, 1, make_ans(5, 6, 0, 0, 0, 1)});
    rows.push_back('{0, '{FUNC_MUL, 0, 0, 0, 0}, 1, make_ans(0, 0, 1, 0, 1, 0)});
    rows.push_back('{0, '{FUNC_SUB, 3, 4, 1, 4}, 0, none});
    rows.push_back('{0, '{FUNC_DIV, 2, 3, 4, 9}, 0, none});
    rows.push_back('{0, '{FUNC_MUL, WMIN, ONE, ONE, ONE}, 0, none});
    rows.push_back('{0, '{FUNC_DIV, WMIN, WMIN, NEG1, ONE}, 0, none});
    rows.push_back('{0, '{FUNC_ADD, WMAX, WMAX, WMAX, WMAX}, 0, none});
    rows.push_back('{0, '{FUNC_SUB, WMIN, NEG1, WMAX, NEG1}, 0, none});
    rows.push_back('{0, '{FUNC_MUL, NEG1, NEG1, NEG1, ONE}, 0, none});
    rows.push_back('{0, '{FUNC_MUL, -5, 7, 3, -2}, 0, none});
    rows.push_back('{0, '{FUNC_DIV, ONE, ONE, '0, ONE}, 0, none});
    rows.push_back('{0, '{FUNC_ADD, WMIN, ONE, '0, ONE}, 0, none});
    rows.push_back('{0, '{FUNC_MUL, 64'sh4000_0000_0000_0000, ONE, 2, ONE}, 0, none});
    rows.push_back('{1, '{FUNC_MUL, WMAX, ONE, 2, ONE}, 1, make_ans(0, 0, 1, 0, 0, 1)});
    rows.push_back('{1, '{FUNC_ADD, WMAX, ONE, ONE, ONE}, 0, none});
    rows.push_back('{1, '{FUNC_SUB, -2, ONE, WMIN, ONE}, 0, none});
    rows.push_back('{1, '{FUNC_SUB, WMIN, ONE, ONE, ONE}, 0, none});
    rows.push_back('{1, '{FUNC_SUB, '0, ONE, WMIN, NEG1}, 0, none});
    rows.push_back('{1, '{FUNC_DIV, WMIN, ONE, NEG1, ONE}, 0, none});
    rows.push_back('{1, '{FUNC_DIV, 6, 4, 9, 2}, 0, none});
    rows.push_back('{1, '{FUNC_MUL, WMIN, NEG1, ONE, ONE}, 0, none});
    rows.push_back('{1, '{FUNC_ADD, -3, -4, -5, -6}, 0, none});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_safe(1'b0);
    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.safe != safe_cur) set_safe(rw.safe);
      offer(rw.op, rw.typed, rw.ans);
    end

    // Random phases, one per idle mode with a random safe_mode, then a hold-off phase in safe mode.
    for (int ph = 0; ph < 5; ph++) begin
      set_safe((ph == 4) ? 1'b1 : 1'(($urandom_range(1))));
      @(negedge clk);
      in_valid <= 1'b0;
      idle_mode = (ph == 4) ? IDLE_NONE : ph;
      // In the last phase the receiver holds off while items keep coming.
      if (ph == 4) hold_left = HOLD_CYCLES;
      for (int k = 0; k < 16; k++) begin
        o.func = 2'($urandom_range(3));
        o.a_num = pick_word();
        o.a_den = pick_word();
        o.b_num = pick_word();
        o.b_den = pick_word();
        offer(o, 1'b0, none);
      end
      @(negedge clk);
      in_valid <= 1'b0;
    end

    wait (pending_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("rational_arith_unit verification clean");
    end else begin
      $display("rational_arith_unit verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
